FILE: src/bf3_pkg.sv
// Shared types and constants of the 3x3 box filter.
// Used by bf3_col_cell and box_filter_3x3_clamped in src; depends on nothing.
package bf3_pkg;

	localparam int BF3_MAX_WIDTH  = 1024;
	localparam int BF3_MAX_HEIGHT = 1024;

	// Configuration register file.
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	localparam int PIX_W     = 8;
	localparam int COL_SUM_W = 10;
	localparam int SUM_W     = 12;

	// floor(x / 9) == (x * 3641) >> 15 for every x below 32768.
	localparam int PROD_W     = 24;
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;

	typedef logic [PIX_W-1:0]     pixel_t;
	typedef logic [COL_SUM_W-1:0] col_sum_t;
	typedef logic [SUM_W-1:0]     sum_t;

	// One window column: rows above, at and below the centre row.
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} col_t;

	// Frame border flags of the output pixel in flight.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} border_t;

	typedef struct packed {
		logic   action;
		pixel_t pixel_value;
	} in_item_t;

	typedef struct packed {
		pixel_t mean_value;
		logic   frame_last;
	} out_item_t;

endpackage

FILE: src/bf3_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
module bf3_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/bf3_col_cell.sv
// One column cell of the 3x3 window: holds three pixels, passes them to its
// left neighbor on each shift and forms the column sum with row clamping.
// Depends on bf3_pkg.
module bf3_col_cell (
	input  logic              clk,
	input  logic              shift,
	input  bf3_pkg::col_t     col_in,
	input  logic              top_edge,
	input  logic              bottom_edge,
	output bf3_pkg::col_t     col_out,
	output bf3_pkg::col_sum_t col_sum
);
	import bf3_pkg::*;

	col_t   col_q;
	pixel_t top_pix;
	pixel_t bot_pix;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	// Rows outside the frame repeat the centre row.
	always_comb begin
		top_pix = top_edge ? col_q.mid : col_q.top;
		bot_pix = bottom_edge ? col_q.mid : col_q.bot;
		col_sum = COL_SUM_W'(top_pix) + COL_SUM_W'(col_q.mid) + COL_SUM_W'(bot_pix);
	end

	assign col_out = col_q;

endmodule

FILE: src/box_filter_3x3_clamped.sv
// Top level of the streaming 3x3 box filter with edge clamping.
// Depends on bf3_pkg, bf3_ram and bf3_col_cell.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_stall, in_data          | pixel or drain request in
//   out     | out_valid, out_stall, out_data       | mean pixel out
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | register write in
//
// One request is taken per clock while in_stall is low. Its result, if any, passes
// the line store read, window and sum stages and is divided by nine into the output
// register. The line stores are not cleared at reset; no pass over them is needed.
// A stalled output holds its register; requests keep entering until every stage
// behind it is full, then in_stall rises. cfg_ready is always high.
module box_filter_3x3_clamped #(
	parameter int MAX_WIDTH  = bf3_pkg::BF3_MAX_WIDTH,
	parameter int MAX_HEIGHT = bf3_pkg::BF3_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bf3_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bf3_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]      cfg_data
);
	import bf3_pkg::*;

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int HB = $clog2(MAX_HEIGHT + 2);
	localparam int RstW = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int RstH = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	// Frame size, stored as size minus one after clamping.
	logic [CB-1:0] w_m1_q;
	logic [HB-1:0] h_m1_q;
	logic [CB-1:0] cfg_w_m1;
	logic [HB-1:0] cfg_h_m1;
	logic          cfg_we;
	logic          cfg_hit;

	logic [CB-1:0] in_col_q;
	logic [HB-1:0] in_row_q;
	logic [CB-1:0] out_col_q;
	logic [HB-1:0] out_row_q;

	logic en_out, en3, en2, en1, acc, mv2;
	logic in_frame, emit;
	pixel_t  pix;
	border_t border;

	logic          v_s1_q;
	logic [CB-1:0] c_s1;
	pixel_t        pix_s1;
	logic          emit_s1;
	border_t       border_s1;

	logic   byp_q;
	pixel_t byp_up_q;
	pixel_t byp_mid_q;
	pixel_t up_rd, mid_rd, up_eff, mid_eff;

	logic     v_s2_q;
	border_t  border_s2;
	col_t     chain [4];
	col_sum_t col_sum [3];
	col_sum_t left_sum, right_sum;
	sum_t     total;

	logic              v_s3_q;
	sum_t              sum_s3;
	logic              last_s3;
	logic [PROD_W-1:0] prod;

	logic      out_valid_q;
	out_item_t out_q;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_comb begin
		int wv;
		int hv;
		wv = int'(cfg_data);
		hv = int'(cfg_data);
		if (wv < 1) wv = 1;
		if (wv > MAX_WIDTH) wv = MAX_WIDTH;
		if (hv < 1) hv = 1;
		if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
		cfg_w_m1 = CB'(wv - 1);
		cfg_h_m1 = HB'(hv - 1);
		unique case (cfg_index) inside
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	// Each stage loads when it is empty or the stage after it moves on.
	assign en_out   = !out_valid_q || !out_stall;
	assign en3      = !v_s3_q || en_out;
	assign en2      = !v_s2_q || en3;
	assign en1      = !v_s1_q || en2;
	assign in_stall = !en1;
	assign acc      = in_valid && en1;
	assign mv2      = v_s1_q && en2;

	always_comb begin
		in_frame = in_row_q <= h_m1_q;
		pix = in_frame ? in_data.pixel_value : '0;
		emit = (in_row_q >= HB'(2)) || ((in_row_q == HB'(1)) && (in_col_q != '0));
		border.top    = out_row_q == '0;
		border.bottom = out_row_q == h_m1_q;
		border.left   = out_col_q == '0;
		border.right  = out_col_q == w_m1_q;
		border.last   = border.bottom && border.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q    <= CB'(RstW - 1);
			h_m1_q    <= HB'(RstH - 1);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: w_m1_q <= cfg_w_m1;
				REG_IMAGE_HEIGHT: h_m1_q <= cfg_h_m1;
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (emit && border.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == w_m1_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HB'(1);
				end else begin
					in_col_q <= in_col_q + CB'(1);
				end
				if (emit) begin
					if (border.right) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HB'(1);
					end else begin
						out_col_q <= out_col_q + CB'(1);
					end
				end
			end
		end
	end

	// Stage 1: line store read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			byp_q  <= 1'b0;
		end else if (en1) begin
			v_s1_q <= in_valid;
			byp_q  <= acc && mv2 && (in_col_q == c_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1      <= in_col_q;
			pix_s1    <= pix;
			emit_s1   <= emit;
			border_s1 <= border;
			byp_up_q  <= mid_eff;
			byp_mid_q <= pix_s1;
		end
	end

	// A read of the column being written in the same cycle takes the new data.
	assign up_eff  = byp_q ? byp_up_q : up_rd;
	assign mid_eff = byp_q ? byp_mid_q : mid_rd;

	bf3_ram #(
		.Width (PIX_W),
		.Depth (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (mv2),
		.waddr (c_s1),
		.wdata (mid_eff),
		.re    (acc),
		.raddr (in_col_q),
		.rdata (up_rd)
	);

	bf3_ram #(
		.Width (PIX_W),
		.Depth (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (mv2),
		.waddr (c_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (in_col_q),
		.rdata (mid_rd)
	);

	// Stage 2: the window. The newest column enters the rightmost cell.
	assign chain[3] = '{top: up_eff, mid: mid_eff, bot: pix_s1};

	for (genvar i = 0; i < 3; i++) begin : g_cell
		bf3_col_cell u_cell (
			.clk         (clk),
			.shift       (mv2),
			.col_in      (chain[i+1]),
			.top_edge    (border_s2.top),
			.bottom_edge (border_s2.bottom),
			.col_out     (chain[i]),
			.col_sum     (col_sum[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (en2) begin
			v_s2_q <= v_s1_q && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			border_s2 <= border_s1;
		end
	end

	always_comb begin
		left_sum  = border_s2.left ? col_sum[1] : col_sum[0];
		right_sum = border_s2.right ? col_sum[1] : col_sum[2];
		total = SUM_W'(left_sum) + SUM_W'(col_sum[1]) + SUM_W'(right_sum);
	end

	// Stage 3: window sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3_q <= 1'b0;
		end else if (en3) begin
			v_s3_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sum_s3  <= total;
			last_s3 <= border_s2.last;
		end
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(DIV9_MUL);

	// Output register: sum divided by nine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.mean_value <= prod[DIV9_SHIFT +: PIX_W];
			out_q.frame_last <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_m1_q)
		else $error("input column beyond frame width");

	a_in_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(in_row_q) <= int'(h_m1_q) + 2)
		else $error("input row ran past the drain rows");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= h_m1_q)
		else $error("output row beyond frame height");

	a_bypass_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> v_s1_q)
		else $error("line store bypass set without a request in stage 1");

	a_emit_path: assert property (@(posedge clk) disable iff (!arst_n)
		(mv2 && emit_s1) |=> v_s2_q)
		else $error("emitting request lost on entering the window");

endmodule

FILE: tb/mean_scoreboard_pkg.sv
// Scoreboard of the 3x3 box filter: predicts every mean from the requests
// it is given and checks the results that leave the block.
// Depends on bf3_pkg for the request, result and register types.
package mean_scoreboard_pkg;
	import bf3_pkg::*;

	class mean_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		pixel_t upper_row [BF3_MAX_WIDTH];
		pixel_t middle_row [BF3_MAX_WIDTH];
		col_t window [3];
		int unsigned in_col;
		int unsigned in_row;
		int unsigned out_col;
		int unsigned out_row;
		out_item_t expected_means [$];
		int unsigned errors;

		function new();
			width_reg = CFG_W'(RST_WIDTH);
			height_reg = CFG_W'(RST_HEIGHT);
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			restart_frame();
			errors = 0;
		endfunction

		function void restart_frame();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		static function int unsigned clamp_size(logic [CFG_W-1:0] raw, int unsigned lim);
			if (raw == '0)
				return 1;
			if (int'(raw) > lim)
				return lim;
			return int'(raw);
		endfunction

		function int unsigned eff_width();
			return clamp_size(width_reg, BF3_MAX_WIDTH);
		endfunction

		function int unsigned eff_height();
			return clamp_size(height_reg, BF3_MAX_HEIGHT);
		endfunction

		// Pixels of one frame plus the drain requests that flush it.
		function int unsigned frame_items();
			return eff_width() * eff_height() + eff_width() + 1;
		endfunction

		function int unsigned pending();
			return expected_means.size();
		endfunction

		// A write to the width or height register also sends the frame back to its first pixel.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = val;
					restart_frame();
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = val;
					restart_frame();
				end
				default: ;
			endcase
		endfunction

		function int unsigned col_total(col_t v, bit top_edge, bit bottom_edge);
			int unsigned top;
			int unsigned bot;
			top = top_edge ? int'(v.mid) : int'(v.top);
			bot = bottom_edge ? int'(v.mid) : int'(v.bot);
			return top + int'(v.mid) + bot;
		endfunction

		function void note_request(in_item_t req);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned centre;
			int unsigned left_sum;
			int unsigned right_sum;
			pixel_t pix;
			bit produces;
			bit top_edge;
			bit bottom_edge;
			bit right_edge;
			bit is_last;
			out_item_t res;
			w = eff_width();
			h = eff_height();
			c = (in_col >= w) ? 0 : in_col;
			// Once the frame has all its pixels, requests only push the pipe.
			pix = (in_row < h) ? req.pixel_value : '0;
			produces = (in_row >= 2) || (in_row == 1 && c >= 1);

			window[0] = window[1];
			window[1] = window[2];
			window[2] = {upper_row[c], middle_row[c], pix};
			upper_row[c] = middle_row[c];
			middle_row[c] = pix;

			in_col = c + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (!produces)
				return;

			top_edge = out_row == 0;
			bottom_edge = out_row + 1 >= h;
			right_edge = out_col + 1 >= w;
			centre = col_total(window[1], top_edge, bottom_edge);
			left_sum = (out_col == 0) ? centre : col_total(window[0], top_edge, bottom_edge);
			right_sum = right_edge ? centre : col_total(window[2], top_edge, bottom_edge);
			is_last = bottom_edge && right_edge;
			res.mean_value = pixel_t'((left_sum + centre + right_sum) / 9);
			res.frame_last = is_last;
			expected_means.push_back(res);

			if (is_last) begin
				restart_frame();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_means.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, mean_value %0d frame_last %0b",
					$time, got.mean_value, got.frame_last);
				return;
			end
			want = expected_means.pop_front();
			if (got.mean_value !== want.mean_value) begin
				errors++;
				$display("%0t: mean_value expected %0d, actual %0d",
					$time, want.mean_value, got.mean_value);
			end
			if (got.frame_last !== want.frame_last) begin
				errors++;
				$display("%0t: frame_last expected %0b, actual %0b",
					$time, want.frame_last, got.frame_last);
			end
		endfunction

		function bit clean();
			if (expected_means.size() != 0) begin
				errors++;
				$display("%0t: %0d expected results never arrived", $time,
					expected_means.size());
			end
			return errors == 0;
		endfunction
	endclass

endpackage

FILE: tb/box_filter_3x3_clamped_tb.sv
// Testbench of the 3x3 box filter: streams frames of many sizes with random
// idling on both channels and checks every mean against mean_scoreboard.
// Depends on bf3_pkg, mean_scoreboard_pkg and the filter RTL.
module box_filter_3x3_clamped_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bf3_pkg::*;
	import mean_scoreboard_pkg::*;

	localparam int unsigned MAX_WAIT = 17;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned DRAIN_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS = 470;
	localparam int unsigned RUN_LIMIT_NS = 12_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	mean_scoreboard book = new();

	box_filter_3x3_clamped dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(out_data);
	end

	function automatic int unsigned draw_wait(bit calm);
		if (calm)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic pixel_t draw_pixel(int unsigned style);
		case (style)
			1: return $urandom_range(0, 1) ? pixel_t'(255) : pixel_t'(0);
			2: return pixel_t'($urandom_range(240, 255));
			default: return pixel_t'($urandom);
		endcase
	endfunction

	// Result side: a random stall before each result, with calm stretches.
	initial begin : result_sink
		int unsigned hold;
		@(negedge clk);
		forever begin
			hold = draw_wait(rx_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && out_valid));
			@(negedge clk);
			if ($urandom_range(0, 47) == 0)
				rx_calm = !rx_calm;
		end
	end

	// Every task below starts and ends at a falling edge.
	task automatic send_request(input bit act, input pixel_t pix);
		int unsigned gap;
		in_item_t req;
		gap = draw_wait(tx_calm);
		req.action = act;
		req.pixel_value = pix;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		book.note_request(req);
		@(negedge clk);
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (book.pending() != 0);
	endtask

	// Requests that end in no result may still be in the pipe; give them time.
	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		logic [CFG_IDX_W-1:0] idx [2];
		logic [CFG_W-1:0] val [2];
		settle();
		if ($urandom_range(0, 1)) begin
			idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
			val = '{w, h};
		end else begin
			idx = '{REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH};
			val = '{h, w};
		end
		cfg_valid <= 1'b1;
		for (int i = 0; i < 2; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			book.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Sends count requests from the start of a frame; pixel requests first, then
	// drain requests. At request pause_at the sender waits for all results.
	task automatic send_frame(input int unsigned count, input int unsigned pause_at,
			input int unsigned style, input bit noisy);
		int unsigned pixels;
		pixels = book.eff_width() * book.eff_height();
		for (int unsigned i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_for_results();
			if (i < pixels)
				send_request(noisy ? 1'($urandom_range(0, 1)) : 1'b0, draw_pixel(style));
			else
				send_request(noisy ? 1'($urandom_range(0, 1)) : 1'b1, pixel_t'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned cut;
		int unsigned style;
		int unsigned sent;
		bit noisy;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset sizes: only the first rows fit in the run, so the frame is cut
		// short and the next register write restarts it.
		send_frame(660, 650, 0, 1'b1);

		configure(11'd3, 11'd3);
		// Inside the frame the action bit is ignored; after it, the pixel is.
		for (int i = 0; i < 9; i++)
			send_request(1'(i % 2), pixel_t'(255));
		for (int i = 0; i < 4; i++)
			send_request(1'(i % 2), pixel_t'(255));
		configure(11'd1, 11'd1);
		send_request(1'b0, pixel_t'(0));
		send_request(1'b1, pixel_t'(255));
		send_request(1'b1, pixel_t'(0));
		// Zero sizes act as one; two frames back to back.
		configure(11'd0, 11'd0);
		send_request(1'b1, pixel_t'(255));
		send_request(1'b0, pixel_t'(17));
		send_request(1'b1, pixel_t'(0));
		send_request(1'b0, pixel_t'(128));
		send_request(1'b1, pixel_t'(0));
		send_request(1'b1, pixel_t'(255));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			configure(CFG_W'(w), CFG_W'(h));
			total = book.frame_items();
			style = $urandom_range(0, 2);
			noisy = $urandom_range(0, 3) == 0;
			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, total - 1);
				send_frame(cut, cut, style, noisy);
				sent += cut;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : total;
					send_frame(total, cut, style, noisy);
					sent += total;
				end
			end
		end

		in_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && book.pending() != 0; n++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (book.clean())
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
